// ----- rtl/core/ecal_pkg.sv -----
package ecal_pkg;

    // first year of the count
    localparam int EPOCH_BASE_YEAR = 2020;

    // 32-bit seconds reach at most this many whole years past the epoch
    localparam int YEAR_SPAN     = 138;
    localparam int YEAR_TAB_LEN  = YEAR_SPAN + 2;
    localparam int YEAR_IDX_W    = $clog2(YEAR_TAB_LEN);
    localparam int DAY_CNT_W     = 16;
    localparam int YEAR_W        = 12;

    // reciprocal multipliers, exact over the full input range of each stage
    localparam logic [31:0] DAY_RECIP  = 32'd3257812231;  // 2^48 / 86400, rounded up
    localparam int          DAY_SHIFT  = 48;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;      // 2^29 / 3600, rounded up
    localparam int          HOUR_SHIFT = 29;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;        // 2^18 / 60, rounded up
    localparam int          MIN_SHIFT  = 18;
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    // year estimate, days / 365.25, within one of the true offset
    localparam logic [15:0] YEAR_RECIP = 16'd45934;       // 2^24 / 365.25
    localparam int          YEAR_SHIFT = 24;

    typedef logic [DAY_CNT_W-1:0] year_tab_t [0:YEAR_TAB_LEN-1];
    typedef logic                 leap_tab_t [0:YEAR_TAB_LEN-1];
    typedef logic [8:0]           month_tab_t [1:12];

    // day of year on which each month starts, common year
    localparam month_tab_t MONTH_START = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic logic is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days from the epoch to 1 january of each year
    function automatic year_tab_t build_year_start();
        year_tab_t t;
        int        acc;
        acc = 0;
        for (int i = 0; i < YEAR_TAB_LEN; i++)
        begin
            t[i] = DAY_CNT_W'(acc);
            acc  = acc + (is_leap(EPOCH_BASE_YEAR + i) ? 366 : 365);
        end
        return t;
    endfunction

    function automatic leap_tab_t build_leap();
        leap_tab_t t;
        for (int i = 0; i < YEAR_TAB_LEN; i++)
        begin
            t[i] = is_leap(EPOCH_BASE_YEAR + i);
        end
        return t;
    endfunction

    localparam year_tab_t YEAR_START = build_year_start();
    localparam leap_tab_t LEAP_YEAR  = build_leap();

endpackage

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+-------------------------------------
// command  | in        | start high, busy low         | elapsed_seconds
// result   | out       | done high for one cycle      | second_of_minute, minute_of_hour,
//          |           |                              | hour_of_day, calendar_year,
//          |           |                              | month_of_year, day_of_month
//
// eight-stage pipeline, one transfer accepted every cycle, busy is always low
// a result appears on done once its command transfer has passed through every stage
// the stages hold the chain of reciprocal multiplies (day, hour, minute)
// and, on the date side, year table lookup, year pick, month compare
// reset clears the valid bits only; the receiver cannot stall, so nothing holds

module epoch_seconds_to_calendar
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] elapsed_seconds,
    output logic        done,
    output logic [5:0]  second_of_minute,
    output logic [5:0]  minute_of_hour,
    output logic [4:0]  hour_of_day,
    output logic [11:0] calendar_year,
    output logic [3:0]  month_of_year,
    output logic [4:0]  day_of_month
);
    import ecal_pkg::*;

    localparam int NSTAGE = 8;

    // valid bits, one per stage
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;

    // stage 1: seconds times day reciprocal
    logic [31:0] secs1_reg;
    logic [63:0] dprod1_reg;

    // stage 2: whole days, days back to seconds, year estimate product
    logic [31:0]          secs2_reg;
    logic [DAY_CNT_W-1:0] days2_reg;
    logic [31:0]          dsecs2_reg;
    logic [31:0]          yprod2_reg;

    // stage 3: second of day, year estimate
    logic [16:0]           sod3_reg;
    logic [DAY_CNT_W-1:0]  days3_reg;
    logic [YEAR_IDX_W-1:0] est3_reg;

    // stage 4: hour product, candidate year starts
    logic [16:0]           sod4_reg;
    logic [34:0]           hprod4_reg;
    logic [DAY_CNT_W-1:0]  days4_reg;
    logic [YEAR_IDX_W-1:0] est4_reg;
    logic [DAY_CNT_W-1:0]  ys_lo4_reg;
    logic [DAY_CNT_W-1:0]  ys_mid4_reg;
    logic [DAY_CNT_W-1:0]  ys_hi4_reg;

    // stage 5: hour and second of hour, chosen year
    logic [4:0]            hour5_reg;
    logic [11:0]           soh5_reg;
    logic [DAY_CNT_W-1:0]  days5_reg;
    logic [YEAR_IDX_W-1:0] yoff5_reg;
    logic [DAY_CNT_W-1:0]  ystart5_reg;

    // stage 6: minute product, day of year
    logic [4:0]            hour6_reg;
    logic [11:0]           soh6_reg;
    logic [24:0]           mprod6_reg;
    logic [YEAR_IDX_W-1:0] yoff6_reg;
    logic [8:0]            doy6_reg;
    logic                  leap6_reg;

    // stage 7: minute and second, month
    logic [4:0]            hour7_reg;
    logic [5:0]            min7_reg;
    logic [5:0]            sec7_reg;
    logic [YEAR_IDX_W-1:0] yoff7_reg;
    logic [8:0]            doy7_reg;
    logic [3:0]            month7_reg;
    logic [8:0]            mstart7_reg;

    // stage 8: output registers
    logic [5:0]  sec8_reg;
    logic [5:0]  min8_reg;
    logic [4:0]  hour8_reg;
    logic [11:0] year8_reg;
    logic [3:0]  month8_reg;
    logic [4:0]  day8_reg;

    // combinational helpers
    logic [DAY_CNT_W-1:0]  days2_next;
    logic [YEAR_IDX_W-1:0] est3_next;
    logic [YEAR_IDX_W-1:0] idx_lo;
    logic [YEAR_IDX_W-1:0] idx_hi;
    logic [4:0]            hour5_next;
    logic [YEAR_IDX_W-1:0] yoff5_next;
    logic [DAY_CNT_W-1:0]  ystart5_next;
    logic [5:0]            min7_next;
    logic [3:0]            month7_next;
    logic [8:0]            mstart7_next;
    logic [8:0]            mbound;

    assign busy = 1'b0;

    // valid bits move every cycle, nothing can hold the pipe
    always_comb
    begin
        vld_next = {vld_reg[NSTAGE-2:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // whole days: top bits of the reciprocal product
    assign days2_next = dprod1_reg[DAY_SHIFT +: DAY_CNT_W];
    assign est3_next  = yprod2_reg[YEAR_SHIFT +: YEAR_IDX_W];

    // the true year offset is the estimate or one either side
    assign idx_lo = (est3_reg == '0) ? '0 : est3_reg - 1'b1;
    assign idx_hi = est3_reg + 1'b1;

    assign hour5_next = hprod4_reg[HOUR_SHIFT +: 5];

    always_comb
    begin
        if (days4_reg >= ys_hi4_reg)
        begin
            yoff5_next   = est4_reg + 1'b1;
            ystart5_next = ys_hi4_reg;
        end
        else if (days4_reg >= ys_mid4_reg)
        begin
            yoff5_next   = est4_reg;
            ystart5_next = ys_mid4_reg;
        end
        else
        begin
            yoff5_next   = (est4_reg == '0) ? '0 : est4_reg - 1'b1;
            ystart5_next = ys_lo4_reg;
        end
    end

    assign min7_next = mprod6_reg[MIN_SHIFT +: 6];

    // month: last month whose first day is not past the day of year
    always_comb
    begin
        month7_next  = 4'd1;
        mstart7_next = '0;
        mbound       = '0;
        for (int m = 2; m <= 12; m++)
        begin
            mbound = MONTH_START[m] + ((leap6_reg && m >= 3) ? 9'd1 : 9'd0);
            if (doy6_reg >= mbound)
            begin
                month7_next  = 4'(m);
                mstart7_next = mbound;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        // stage 1
        secs1_reg  <= elapsed_seconds;
        dprod1_reg <= 64'(elapsed_seconds) * 64'(DAY_RECIP);

        // stage 2
        secs2_reg  <= secs1_reg;
        days2_reg  <= days2_next;
        dsecs2_reg <= 32'(days2_next) * 32'(SECS_PER_DAY);
        yprod2_reg <= 32'(days2_next) * 32'(YEAR_RECIP);

        // stage 3
        sod3_reg  <= 17'(secs2_reg - dsecs2_reg);
        days3_reg <= days2_reg;
        est3_reg  <= est3_next;

        // stage 4
        sod4_reg    <= sod3_reg;
        hprod4_reg  <= 35'(sod3_reg) * 35'(HOUR_RECIP);
        days4_reg   <= days3_reg;
        est4_reg    <= est3_reg;
        ys_lo4_reg  <= YEAR_START[idx_lo];
        ys_mid4_reg <= YEAR_START[est3_reg];
        ys_hi4_reg  <= YEAR_START[idx_hi];

        // stage 5
        hour5_reg   <= hour5_next;
        soh5_reg    <= 12'(sod4_reg - 17'(hour5_next) * 17'(SECS_PER_HOUR));
        days5_reg   <= days4_reg;
        yoff5_reg   <= yoff5_next;
        ystart5_reg <= ystart5_next;

        // stage 6
        hour6_reg  <= hour5_reg;
        soh6_reg   <= soh5_reg;
        mprod6_reg <= 25'(soh5_reg) * 25'(MIN_RECIP);
        yoff6_reg  <= yoff5_reg;
        doy6_reg   <= 9'(days5_reg - ystart5_reg);
        leap6_reg  <= LEAP_YEAR[yoff5_reg];

        // stage 7
        hour7_reg   <= hour6_reg;
        min7_reg    <= min7_next;
        sec7_reg    <= 6'(soh6_reg - 12'(min7_next) * 12'(SECS_PER_MIN));
        yoff7_reg   <= yoff6_reg;
        doy7_reg    <= doy6_reg;
        month7_reg  <= month7_next;
        mstart7_reg <= mstart7_next;

        // stage 8
        sec8_reg   <= sec7_reg;
        min8_reg   <= min7_reg;
        hour8_reg  <= hour7_reg;
        year8_reg  <= YEAR_W'(EPOCH_BASE_YEAR) + YEAR_W'(yoff7_reg);
        month8_reg <= month7_reg;
        day8_reg   <= 5'(doy7_reg - mstart7_reg + 9'd1);
    end

    assign done             = vld_reg[NSTAGE-1];
    assign second_of_minute = sec8_reg;
    assign minute_of_hour   = min8_reg;
    assign hour_of_day      = hour8_reg;
    assign calendar_year    = year8_reg;
    assign month_of_year    = month8_reg;
    assign day_of_month     = day8_reg;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import ecal_pkg::*;

    // one converted date and time, field widths as on the result ports
    typedef struct packed
    {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [11:0] calendar_year;
        logic [3:0]  month_of_year;
        logic [4:0]  day_of_month;
    } calendar_t;

    localparam int unsigned SECONDS_IN_DAY = 86400;
    localparam int unsigned LAST_DAY_INDEX = 49710;   // whole days in the 32-bit range
    localparam int unsigned LAST_YEAR_STEP = 136;     // last year that starts inside the range
    localparam int          CLK_HALF       = 5;
    localparam int          DRAIN_CYCLES   = 20;      // pipeline is eight deep
    localparam int          RANDOM_ITEMS   = 1400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] elapsed_seconds;
    logic        done;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [11:0] calendar_year;
    logic [3:0]  month_of_year;
    logic [4:0]  day_of_month;

    epoch_seconds_to_calendar dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .elapsed_seconds  (elapsed_seconds),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .calendar_year    (calendar_year),
        .month_of_year    (month_of_year),
        .day_of_month     (day_of_month)
    );

    // gregorian rule: every fourth year, except centuries not divisible by 400
    function automatic bit gregorian_leap(int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_year(int unsigned yr);
        return gregorian_leap(yr) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
        case (mon)
            2:             return gregorian_leap(yr) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // day count from the epoch to 1 january of the year some steps later
    function automatic int unsigned year_start_day(int unsigned steps);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < steps; i++)
        begin
            acc += days_in_year(EPOCH_BASE_YEAR + i);
        end
        return acc;
    endfunction

    function automatic logic [31:0] at_day(int unsigned day_idx, int unsigned secs_into_day);
        return 32'(day_idx * SECONDS_IN_DAY + secs_into_day);
    endfunction

    // expected conversion: peel off time of day, then whole years, then whole months
    function automatic calendar_t convert_seconds(logic [31:0] secs);
        calendar_t   r;
        int unsigned count;
        int unsigned days_left;
        int unsigned yr;
        int unsigned mon;
        count     = secs;
        days_left = count / SECONDS_IN_DAY;
        yr        = EPOCH_BASE_YEAR;
        mon       = 1;
        while (days_left >= days_in_year(yr))
        begin
            days_left -= days_in_year(yr);
            yr++;
        end
        while (mon <= 12 && days_left >= days_in_month(mon, yr))
        begin
            days_left -= days_in_month(mon, yr);
            mon++;
        end
        r.second_of_minute = 6'(count % 60);
        r.minute_of_hour   = 6'((count / 60) % 60);
        r.hour_of_day      = 5'((count / 3600) % 24);
        r.calendar_year    = 12'(yr);
        r.month_of_year    = 4'(mon);
        r.day_of_month     = 5'(days_left + 1);
        return r;
    endfunction

    // in-order store of converted dates still owed by the pipeline
    class calendar_scoreboard;
        calendar_t   owed_dates[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        function void note_command(logic [31:0] secs);
            owed_dates.push_back(convert_seconds(secs));
        endfunction

        function int unsigned outstanding();
            return owed_dates.size();
        endfunction

        function void compare_field(string field, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(calendar_t got);
            calendar_t want;
            if (owed_dates.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                failures++;
                return;
            end
            want = owed_dates.pop_front();
            compare_field("second_of_minute", 12'(want.second_of_minute),
                          12'(got.second_of_minute));
            compare_field("minute_of_hour", 12'(want.minute_of_hour), 12'(got.minute_of_hour));
            compare_field("hour_of_day", 12'(want.hour_of_day), 12'(got.hour_of_day));
            compare_field("calendar_year", want.calendar_year, got.calendar_year);
            compare_field("month_of_year", 12'(want.month_of_year), 12'(got.month_of_year));
            compare_field("day_of_month", 12'(want.day_of_month), 12'(got.day_of_month));
        endfunction
    endclass

    calendar_scoreboard date_board;
    bit                 back_to_back;   // a stretch of commands with no idle cycles

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // result side: the receiver cannot stall, so every done cycle is a transfer
    // sampled at the edge that ends the cycle, outputs still hold pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($isunknown(done))
            begin
                $error("done is unknown after reset");
                date_board.failures++;
            end
            else if (done)
            begin
                date_board.check_result('{second_of_minute, minute_of_hour, hour_of_day,
                                          calendar_year, month_of_year, day_of_month});
            end
        end
    end

    // idle length: mostly none or short, now and then long, none in a burst
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (back_to_back || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic idle_cycles(int unsigned n);
        if (n != 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // command transfer: hold start with the value until busy is seen low at an edge
    task automatic send_command(logic [31:0] secs);
        idle_cycles(pick_gap());
        start           <= 1'b1;
        elapsed_seconds <= secs;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        date_board.note_command(secs);
    endtask

    // random count: plain 32-bit, a random day, near a new year, or near the top
    function automatic logic [31:0] random_seconds();
        int unsigned kind;
        int unsigned day_idx;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return $urandom;
        else if (kind < 7)
            return at_day($urandom_range(0, LAST_DAY_INDEX - 1), $urandom_range(0, 86399));
        else if (kind < 9)
        begin
            // last day of one year or first day of the next
            day_idx = year_start_day($urandom_range(1, LAST_YEAR_STEP)) - $urandom_range(0, 1);
            return at_day(day_idx, $urandom_range(0, 86399));
        end
        else
            return 32'hFFFF_FFFF - $urandom_range(0, 400000);
    endfunction

    initial
    begin
        logic [31:0] corner_values[$];
        int unsigned century_day;
        int unsigned top_year_day;

        date_board      = new();
        back_to_back    = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        elapsed_seconds = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        century_day  = year_start_day(2100 - EPOCH_BASE_YEAR);
        top_year_day = year_start_day(LAST_YEAR_STEP);

        // field extremes, leap day of the epoch year, the non-leap century
        // year, year rollovers and the very top of the 32-bit count
        corner_values = '{
            32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            at_day(58, 0), at_day(59, 43199), at_day(60, 0),
            at_day(365, 86399), at_day(366, 0), at_day(366 + 59, 0),
            at_day(century_day + 58, 86399), at_day(century_day + 59, 0),
            at_day(top_year_day - 1, 86399), at_day(top_year_day, 0),
            32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
            32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        foreach (corner_values[i])
            send_command(corner_values[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // switch between bursts and gappy stretches now and then
            if (i % 150 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            // hold off once mid-run until the pipeline has fully drained
            if (i == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (date_board.outstanding() != 0)
                    @(posedge clk);
            end
            send_command(random_seconds());
        end
        start <= 1'b0;

        // drain, then give any stray result time to show up
        while (date_board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (date_board.failures == 0 && date_board.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
